@@ sv/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// shared codes, reset values and widths of the pool free list allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W  = 32;
    localparam int CHUNK_W = 17;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CHUNK_W-1:0] t_chunk;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // item kinds
    localparam t_kind KIND_ALLOC      = 2'd0;
    localparam t_kind KIND_FREE       = 2'd1;
    localparam t_kind KIND_POOL_RESET = 2'd2;

    // result status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_SIZE     = 2'd2;
    localparam t_status ST_FREE_ERR = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx REG_BASE  = 1'd0;
    localparam t_cfg_idx REG_CHUNK = 1'd1;

    // register reset values
    localparam t_addr  RESET_BASE  = 32'd0;
    localparam t_chunk RESET_CHUNK = 17'd64;

endpackage

@@ sv/pfa_stack_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_stack_ram
// free stack storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pfa_stack_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  pfa_pkg::t_addr   i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output pfa_pkg::t_addr   o_rdata
);

    pfa_pkg::t_addr r_mem [DEPTH];
    pfa_pkg::t_addr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/pfa_fill.sv @@
// ----------------------------------------------------------------------------
// pfa_fill
// refill sequencer: writes base + i*step into entry i, one entry per cycle
// ----------------------------------------------------------------------------
module pfa_fill #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pfa_pkg::t_addr   i_base,
    input  pfa_pkg::t_chunk  i_step,
    output logic             o_busy,
    output logic [AW-1:0]    o_idx,
    output pfa_pkg::t_addr   o_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic            r_active;
    logic [AW-1:0]   r_idx;
    pfa_pkg::t_addr  r_addr;
    pfa_pkg::t_chunk r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // walk with the register reset values after a chip reset
            r_active <= 1'b1;
            r_idx    <= '0;
            r_addr   <= pfa_pkg::RESET_BASE;
            r_step   <= pfa_pkg::RESET_CHUNK;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_addr   <= i_base;
            r_step   <= i_step;
        end else if (r_active) begin
            r_addr <= r_addr + {15'd0, r_step};
            r_idx  <= r_idx + AW'(1);
            if (r_idx == LAST_IDX) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_busy = r_active;
    assign o_idx  = r_idx;
    assign o_data = r_addr;

endmodule

@@ sv/pool_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// pool_free_list_allocator_core
// fixed-size chunk pool allocator on a lifo free stack of chunk addresses
// ----------------------------------------------------------------------------
//  channel   ports                                           direction
//  command   start, busy, i_kind, i_request_size,
//            i_free_address                                  in, busy out
//  result    o_valid, o_address, o_status, o_used_bytes,
//            o_peak_bytes                                    out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,
//            i_cfg_data                                      in
//
// allocate, free and no-op words are taken one per cycle while busy is low; each result
// passes the s1 stage and the result registers, behind the stack ram read.
// a pool reset word, and the chip reset, start a refill walk through all NUM_CHUNKS
// entries of the stack ram; busy stays high during the walk.
// config writes are always taken (o_cfg_ready is tied high).
// results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pool_free_list_allocator_core #(
    parameter int NUM_CHUNKS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pfa_pkg::t_kind        i_kind,
    input  pfa_pkg::t_chunk       i_request_size,
    input  pfa_pkg::t_addr        i_free_address,
    output logic                  o_valid,
    output pfa_pkg::t_addr        o_address,
    output pfa_pkg::t_status      o_status,
    output pfa_pkg::t_addr        o_used_bytes,
    output pfa_pkg::t_addr        o_peak_bytes,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  pfa_pkg::t_cfg_idx     i_cfg_index,
    input  pfa_pkg::t_addr        i_cfg_data
);

    localparam int AW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CW = $clog2(NUM_CHUNKS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_CHUNKS);

    // configuration registers
    pfa_pkg::t_addr  r_base;
    pfa_pkg::t_chunk r_chunk;

    // allocator state
    logic [CW-1:0]   r_count;
    pfa_pkg::t_addr  r_used;
    pfa_pkg::t_addr  r_peak;

    // stage between accept and result
    logic             r_s1_valid;
    logic             r_s1_pop;
    pfa_pkg::t_status r_s1_status;
    pfa_pkg::t_addr   r_s1_used;
    pfa_pkg::t_addr   r_s1_peak;

    // result registers
    logic             r_o_valid;
    pfa_pkg::t_addr   r_o_address;
    pfa_pkg::t_status r_o_status;
    pfa_pkg::t_addr   r_o_used;
    pfa_pkg::t_addr   r_o_peak;

    logic             fill_busy;
    logic [AW-1:0]    fill_idx;
    pfa_pkg::t_addr   fill_data;
    logic             fill_start;

    logic             accept;
    logic             pop_ok;
    logic             push_ok;
    pfa_pkg::t_status n_status;
    pfa_pkg::t_addr   n_used;
    pfa_pkg::t_addr   n_peak;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    count_m1;
    logic [32:0]      used_sum;
    pfa_pkg::t_addr   used_inc;
    pfa_pkg::t_addr   chunk_ext;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    pfa_pkg::t_addr   ram_wdata;
    pfa_pkg::t_addr   ram_rdata;

    assign busy        = fill_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !fill_busy;
    assign chunk_ext   = {15'd0, r_chunk};
    assign count_m1    = r_count - CW'(1);
    assign used_sum    = {1'b0, r_used} + {1'b0, chunk_ext};
    // saturate the used count at the top of the 32 bit range
    assign used_inc    = used_sum[32] ? '1 : used_sum[31:0];

    always_comb begin
        pop_ok     = 1'b0;
        push_ok    = 1'b0;
        fill_start = 1'b0;
        n_status   = pfa_pkg::ST_OK;
        n_used     = r_used;
        n_peak     = r_peak;
        n_count    = r_count;
        unique case (i_kind)
            pfa_pkg::KIND_ALLOC: begin
                if (i_request_size != r_chunk) begin
                    n_status = pfa_pkg::ST_SIZE;
                end else if (r_count == '0) begin
                    n_status = pfa_pkg::ST_EMPTY;
                end else begin
                    pop_ok  = 1'b1;
                    n_count = count_m1;
                    n_used  = used_inc;
                    if (used_inc > r_peak) begin
                        n_peak = used_inc;
                    end
                end
            end
            pfa_pkg::KIND_FREE: begin
                if (r_count >= FULL_COUNT || r_used < chunk_ext) begin
                    n_status = pfa_pkg::ST_FREE_ERR;
                end else begin
                    push_ok = 1'b1;
                    n_count = r_count + CW'(1);
                    n_used  = r_used - chunk_ext;
                end
            end
            pfa_pkg::KIND_POOL_RESET: begin
                fill_start = 1'b1;
                n_count    = FULL_COUNT;
                n_used     = '0;
                n_peak     = '0;
            end
            default: begin
                // unused kind: no operation
            end
        endcase
    end

    // refill walk owns the write port; no word is taken while it runs
    always_comb begin
        if (fill_busy) begin
            ram_we    = 1'b1;
            ram_waddr = fill_idx;
            ram_wdata = fill_data;
        end else begin
            ram_we    = accept && push_ok;
            ram_waddr = r_count[AW-1:0];
            ram_wdata = i_free_address;
        end
    end

    pfa_fill #(
        .DEPTH (NUM_CHUNKS),
        .AW    (AW)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && fill_start),
        .i_base  (r_base),
        .i_step  (r_chunk),
        .o_busy  (fill_busy),
        .o_idx   (fill_idx),
        .o_data  (fill_data)
    );

    pfa_stack_ram #(
        .DEPTH (NUM_CHUNKS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (count_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= pfa_pkg::RESET_BASE;
            r_chunk <= pfa_pkg::RESET_CHUNK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfa_pkg::REG_BASE:  r_base  <= i_cfg_data;
                pfa_pkg::REG_CHUNK: r_chunk <= i_cfg_data[pfa_pkg::CHUNK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= FULL_COUNT;
            r_used     <= '0;
            r_peak     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_o_valid  <= r_s1_valid;
            if (accept) begin
                r_count <= n_count;
                r_used  <= n_used;
                r_peak  <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop    <= pop_ok;
            r_s1_status <= n_status;
            r_s1_used   <= n_used;
            r_s1_peak   <= n_peak;
        end
        if (r_s1_valid) begin
            // popped address arrives from the ram in the cycle after the accept
            r_o_address <= r_s1_pop ? ram_rdata : '0;
            r_o_status  <= r_s1_status;
            r_o_used    <= r_s1_used;
            r_o_peak    <= r_s1_peak;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_address    = r_o_address;
    assign o_status     = r_o_status;
    assign o_used_bytes = r_o_used;
    assign o_peak_bytes = r_o_peak;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pool free list allocator: words are fed from a
// queue of pending commands, every result is checked field by field against
// an in-bench model of the free stack and the byte counters
// ----------------------------------------------------------------------------
module tb_top;

    localparam int              NUM_CHUNKS    = 256;
    localparam pfa_pkg::t_kind  KIND_NOP      = 2'd3;
    localparam pfa_pkg::t_chunk CHUNK_MIN     = 17'd8;
    localparam pfa_pkg::t_chunk CHUNK_MAX     = 17'd65536;
    localparam int              DRAIN_QUIET   = 4;
    localparam int              SETTLE_CYCLES = NUM_CHUNKS + 40;
    localparam int              STALL_LIMIT   = 8 * NUM_CHUNKS;
    localparam int              GAP_PCT       = 6;
    localparam int              NO_GAP_FROM   = 300;
    localparam int              NO_GAP_TO     = 500;

    typedef enum logic [1:0] {CMD_WORD, CMD_CFG, CMD_DRAIN} t_cmd_tag;

    typedef struct {
        t_cmd_tag          tag;
        pfa_pkg::t_kind    kind;
        pfa_pkg::t_chunk   req_size;
        pfa_pkg::t_addr    free_addr;
        pfa_pkg::t_cfg_idx reg_idx;
        pfa_pkg::t_addr    reg_data;
    } t_pool_cmd;

    typedef struct {
        pfa_pkg::t_addr   address;
        pfa_pkg::t_status status;
        pfa_pkg::t_addr   used;
        pfa_pkg::t_addr   peak;
    } t_pool_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    pfa_pkg::t_kind    i_kind         = pfa_pkg::KIND_ALLOC;
    pfa_pkg::t_chunk   i_request_size = '0;
    pfa_pkg::t_addr    i_free_address = '0;
    logic              o_valid;
    pfa_pkg::t_addr    o_address;
    pfa_pkg::t_status  o_status;
    pfa_pkg::t_addr    o_used_bytes;
    pfa_pkg::t_addr    o_peak_bytes;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    pfa_pkg::t_cfg_idx i_cfg_index    = pfa_pkg::REG_BASE;
    pfa_pkg::t_addr    i_cfg_data     = '0;

    pool_free_list_allocator_core #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_valid        (o_valid),
        .o_address      (o_address),
        .o_status       (o_status),
        .o_used_bytes   (o_used_bytes),
        .o_peak_bytes   (o_peak_bytes),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // pool model
    pfa_pkg::t_addr  free_stk [NUM_CHUNKS];
    int unsigned     free_cnt;
    pfa_pkg::t_addr  used_sum;
    pfa_pkg::t_addr  peak_sum;
    pfa_pkg::t_addr  pool_base;
    pfa_pkg::t_chunk pool_chunk;

    t_pool_cmd    cmd_queue[$];
    t_pool_result owed_results[$];
    int           words_sent   = 0;
    int           quiet_cycles = 0;
    int           stall_cycles = 0;
    int           mismatches   = 0;

    // register values the stimulus is currently built for
    pfa_pkg::t_addr  gen_base;
    pfa_pkg::t_chunk gen_chunk;

    function automatic void refill_pool();
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            free_stk[i] = pool_base + pfa_pkg::t_addr'(i) * pool_chunk;
        end
        free_cnt = NUM_CHUNKS;
        used_sum = '0;
        peak_sum = '0;
    endfunction

    function automatic t_pool_result pool_step(pfa_pkg::t_kind kind, pfa_pkg::t_chunk req,
                                               pfa_pkg::t_addr faddr);
        t_pool_result            res;
        logic [pfa_pkg::ADDR_W:0] grown;
        res.address = '0;
        res.status  = pfa_pkg::ST_OK;
        case (kind)
            pfa_pkg::KIND_ALLOC: begin
                if (req != pool_chunk) begin
                    res.status = pfa_pkg::ST_SIZE;
                end else if (free_cnt == 0) begin
                    res.status = pfa_pkg::ST_EMPTY;
                end else begin
                    free_cnt--;
                    res.address = free_stk[free_cnt];
                    // used bytes saturate instead of wrapping
                    grown = used_sum + pool_chunk;
                    used_sum = grown[pfa_pkg::ADDR_W] ? '1 : grown[pfa_pkg::ADDR_W-1:0];
                    if (used_sum > peak_sum) begin
                        peak_sum = used_sum;
                    end
                end
            end
            pfa_pkg::KIND_FREE: begin
                if (free_cnt >= NUM_CHUNKS || used_sum < pool_chunk) begin
                    res.status = pfa_pkg::ST_FREE_ERR;
                end else begin
                    free_stk[free_cnt] = faddr;
                    free_cnt++;
                    used_sum -= pool_chunk;
                end
            end
            pfa_pkg::KIND_POOL_RESET: begin
                refill_pool();
            end
            default: begin
            end
        endcase
        res.used = used_sum;
        res.peak = peak_sum;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_word(pfa_pkg::t_kind kind, pfa_pkg::t_chunk req,
                             pfa_pkg::t_addr faddr);
        t_pool_cmd c;
        c.tag       = CMD_WORD;
        c.kind      = kind;
        c.req_size  = req;
        c.free_addr = faddr;
        c.reg_idx   = pfa_pkg::REG_BASE;
        c.reg_data  = '0;
        cmd_queue.push_back(c);
    endtask

    // wait for the block to go quiet, then write both registers
    task automatic reconfigure(pfa_pkg::t_addr base, pfa_pkg::t_chunk chunk);
        t_pool_cmd c;
        c.tag       = CMD_DRAIN;
        c.kind      = KIND_NOP;
        c.req_size  = '0;
        c.free_addr = '0;
        c.reg_idx   = pfa_pkg::REG_BASE;
        c.reg_data  = '0;
        cmd_queue.push_back(c);
        c.tag      = CMD_CFG;
        c.reg_data = base;
        cmd_queue.push_back(c);
        c.reg_idx  = pfa_pkg::REG_CHUNK;
        c.reg_data = pfa_pkg::t_addr'(chunk);
        cmd_queue.push_back(c);
        gen_base  = base;
        gen_chunk = chunk;
    endtask

    function automatic pfa_pkg::t_addr pick_free_addr();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return gen_base
                               + pfa_pkg::t_addr'($urandom_range(NUM_CHUNKS - 1)) * gen_chunk;
            default: return pfa_pkg::t_addr'($urandom());
        endcase
    endfunction

    function automatic pfa_pkg::t_chunk pick_chunk();
        case ($urandom_range(3))
            0:       return CHUNK_MIN;
            1:       return CHUNK_MAX;
            default: return pfa_pkg::t_chunk'($urandom_range(CHUNK_MAX, CHUNK_MIN));
        endcase
    endfunction

    // mostly well-formed allocate/free traffic with some noise mixed in
    task automatic random_run(int count, int alloc_pct, int free_pct);
        int              pick;
        pfa_pkg::t_chunk bad;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < alloc_pct) begin
                push_word(pfa_pkg::KIND_ALLOC, gen_chunk, pfa_pkg::t_addr'($urandom()));
            end else if (pick < alloc_pct + free_pct) begin
                push_word(pfa_pkg::KIND_FREE, pfa_pkg::t_chunk'($urandom_range(CHUNK_MAX)),
                          pick_free_addr());
            end else begin
                case ($urandom_range(3))
                    0, 1: begin
                        bad = pfa_pkg::t_chunk'($urandom_range(CHUNK_MAX));
                        if (bad == gen_chunk) begin
                            bad = bad - 1'b1;
                        end
                        push_word(pfa_pkg::KIND_ALLOC, bad, pfa_pkg::t_addr'($urandom()));
                    end
                    2: begin
                        push_word(KIND_NOP, pfa_pkg::t_chunk'($urandom_range(CHUNK_MAX)),
                                  pfa_pkg::t_addr'($urandom()));
                    end
                    default: begin
                        push_word(pfa_pkg::KIND_POOL_RESET,
                                  pfa_pkg::t_chunk'($urandom_range(CHUNK_MAX)),
                                  pfa_pkg::t_addr'($urandom()));
                    end
                endcase
            end
        end
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        bit        next_start;
        bit        next_cfg;
        bit        gap;
        t_pool_cmd c;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            pool_base    = pfa_pkg::RESET_BASE;
            pool_chunk   = pfa_pkg::RESET_CHUNK;
            refill_pool();
            quiet_cycles = 0;
        end else begin
            if (start && !busy) begin
                owed_results.push_back(pool_step(i_kind, i_request_size, i_free_address));
                words_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pfa_pkg::REG_BASE) begin
                    pool_base = i_cfg_data;
                end else if (i_cfg_index == pfa_pkg::REG_CHUNK) begin
                    pool_chunk = pfa_pkg::t_chunk'(i_cfg_data);
                end
            end
            // o_valid is part of the test so a same-edge pop cannot change the outcome
            if (owed_results.size() == 0 && !o_valid && !busy && !start && !i_cfg_valid) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!(start && busy) && !(i_cfg_valid && !o_cfg_ready)) begin
                next_start = 1'b0;
                next_cfg   = 1'b0;
                gap = (words_sent < NO_GAP_FROM || words_sent >= NO_GAP_TO)
                      && ($urandom_range(99) < GAP_PCT);
                if (!gap && cmd_queue.size() != 0) begin
                    if (cmd_queue[0].tag == CMD_DRAIN) begin
                        if (quiet_cycles >= DRAIN_QUIET) begin
                            void'(cmd_queue.pop_front());
                        end
                    end else begin
                        c = cmd_queue.pop_front();
                        if (c.tag == CMD_WORD) begin
                            next_start     = 1'b1;
                            i_kind         <= c.kind;
                            i_request_size <= c.req_size;
                            i_free_address <= c.free_addr;
                        end else begin
                            next_cfg    = 1'b1;
                            i_cfg_index <= c.reg_idx;
                            i_cfg_data  <= c.reg_data;
                        end
                    end
                end
                start       <= next_start;
                i_cfg_valid <= next_cfg;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pool_result want;
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                $error("result word with nothing outstanding: address %h status %h",
                       o_address, o_status);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                check_field("address", want.address, o_address);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("used_bytes", want.used, o_used_bytes);
                check_field("peak_bytes", want.peak, o_peak_bytes);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        gen_base  = pfa_pkg::RESET_BASE;
        gen_chunk = pfa_pkg::RESET_CHUNK;

        // reset register values
        push_word(pfa_pkg::KIND_FREE, gen_chunk, '0);           // nothing in use yet
        push_word(pfa_pkg::KIND_ALLOC, '0, '0);
        push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX, '1);
        push_word(pfa_pkg::KIND_ALLOC, gen_chunk, '0);
        push_word(pfa_pkg::KIND_ALLOC, gen_chunk, '1);
        push_word(KIND_NOP, CHUNK_MAX, '1);
        push_word(pfa_pkg::KIND_FREE, gen_chunk, '1);
        push_word(pfa_pkg::KIND_FREE, '0, '0);
        push_word(pfa_pkg::KIND_FREE, gen_chunk, 32'h5555_aaaa);
        push_word(pfa_pkg::KIND_ALLOC, gen_chunk, '0);          // lifo: gets address 0 back
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);
        push_word(pfa_pkg::KIND_ALLOC, gen_chunk, '0);

        // top of memory with the largest chunk: addresses wrap
        reconfigure('1, CHUNK_MAX);
        push_word(pfa_pkg::KIND_POOL_RESET, CHUNK_MAX, '1);
        push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX, '0);
        push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX - 1'b1, '0);
        push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX, '0);

        // shrink the chunk while in use: stack fills up before usage hits zero
        reconfigure('1, CHUNK_MIN);
        repeat (3) push_word(pfa_pkg::KIND_FREE, CHUNK_MIN, pfa_pkg::t_addr'($urandom()));
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);

        reconfigure(pfa_pkg::t_addr'($urandom()), pfa_pkg::RESET_CHUNK);
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);
        random_run(100, 45, 45);
        // alloc-heavy so the pool runs dry, then drain it back
        reconfigure(pfa_pkg::t_addr'($urandom()), CHUNK_MIN);
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);
        random_run(340, 90, 5);
        random_run(120, 10, 80);
        reconfigure(pfa_pkg::t_addr'($urandom()), pick_chunk());
        random_run(120, 50, 40);

        // largest chunk at a random base: allocate, free and refill
        reconfigure(pfa_pkg::t_addr'($urandom()), CHUNK_MAX);
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);
        repeat (2) push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX, '0);
        push_word(pfa_pkg::KIND_FREE, CHUNK_MAX, '1);
        push_word(pfa_pkg::KIND_POOL_RESET, '0, '0);
        push_word(pfa_pkg::KIND_ALLOC, CHUNK_MAX, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || start || i_cfg_valid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
